// ----- design/pdct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the prescaled down-counter timer.
package pdct_pkg;

  localparam int COUNT_WIDTH   = 32;
  localparam int DIVIDER_WIDTH = 10;
  localparam int CTRL_WIDTH    = 10;
  localparam int PRESC_WIDTH   = 8;

  localparam logic [DIVIDER_WIDTH-1:0] DIV_RESET = DIVIDER_WIDTH'(125);

  localparam int CTL_WIDE_BIT   = 1;
  localparam int CTL_PRESC_LSB  = 2;
  localparam int CTL_IRQ_EN_BIT = 5;
  localparam int CTL_ENABLE_BIT = 7;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    REG_LOAD    = 4'd0,
    REG_VALUE   = 4'd1,
    REG_CONTROL = 4'd2,
    REG_CLEAR   = 4'd3,
    REG_RAW     = 4'd4,
    REG_MASKED  = 4'd5,
    REG_RELOAD  = 4'd6,
    REG_PREDIV  = 4'd7,
    REG_FREERUN = 4'd8
  } reg_idx_t;

  typedef enum logic [1:0] {
    PRESC_DIV1   = 2'd0,
    PRESC_DIV16  = 2'd1,
    PRESC_DIV256 = 2'd2,
    PRESC_ALT1   = 2'd3
  } presc_sel_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        irq_raw;
  } rsp_t;

endpackage

// ----- design/pdct_req_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel that carries timer requests.
interface pdct_req_if;
  logic           valid;
  logic           ready;
  pdct_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pdct_rsp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel that carries timer results.
interface pdct_rsp_if;
  logic           valid;
  logic           ready;
  pdct_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/prescaled_down_counter_timer.sv -----
`timescale 1ns / 1ps
// Timer top level: request register, state update logic and result register.
// An accepted request is held in the request register; its result goes to the result register.
// Throughput: one request per cycle while results are taken; the single update path sets the rate.
// A stalled result holds the pipeline while the input register is still free.
// Reset is synchronous and active low: all timer state clears, the predivider
// setting returns to 125 and both pipeline stages empty.
module prescaled_down_counter_timer (
  input  logic              clk,
  input  logic              rst_n,
  pdct_req_if.sink          in_req,
  pdct_rsp_if.source        out_rsp
);

  localparam int CW = pdct_pkg::COUNT_WIDTH;
  localparam int DW = pdct_pkg::DIVIDER_WIDTH;
  localparam int PW = pdct_pkg::PRESC_WIDTH;

  logic                  s1_valid_r;
  pdct_pkg::req_t        s1_req_r;
  logic                  out_valid_r;
  pdct_pkg::rsp_t        rsp_r;
  pdct_pkg::rsp_t        rsp_nxt;
  logic                  advance;

  logic [CW-1:0]         reload_r, reload_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [pdct_pkg::CTRL_WIDTH-1:0] ctrl_r, ctrl_nxt;
  logic [DW-1:0]         div_set_r, div_set_nxt;
  logic [DW-1:0]         div_cnt_r, div_cnt_nxt;
  logic [PW-1:0]         presc_r, presc_nxt;
  logic                  irq_r, irq_nxt;

  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = rsp_r;

  always_comb begin
    logic [CW-1:0] cmask;
    logic [CW-1:0] count_m;
    logic [PW-1:0] pmask;
    logic [31:0]   rd;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    ctrl_nxt    = ctrl_r;
    div_set_nxt = div_set_r;
    div_cnt_nxt = div_cnt_r;
    presc_nxt   = presc_r;
    irq_nxt     = irq_r;
    rd          = '0;
    cmask   = ctrl_r[pdct_pkg::CTL_WIDE_BIT] ? {CW{1'b1}} : CW'(17'h0FFFF);
    count_m = count_r & cmask;
    unique case (pdct_pkg::presc_sel_t'(ctrl_r[pdct_pkg::CTL_PRESC_LSB +: 2]))
      pdct_pkg::PRESC_DIV16:  pmask = PW'(8'h0F);
      pdct_pkg::PRESC_DIV256: pmask = PW'(8'hFF);
      default:                pmask = '0;
    endcase
    unique case (s1_req_r.cmd)
      pdct_pkg::CMD_WRITE: begin
        unique case (s1_req_r.reg_index)
          pdct_pkg::REG_LOAD: begin
            reload_nxt = s1_req_r.write_data[CW-1:0];
            count_nxt  = s1_req_r.write_data[CW-1:0];
          end
          pdct_pkg::REG_CONTROL: ctrl_nxt = s1_req_r.write_data[pdct_pkg::CTRL_WIDTH-1:0];
          pdct_pkg::REG_CLEAR:   irq_nxt = 1'b0;
          pdct_pkg::REG_RELOAD:  reload_nxt = s1_req_r.write_data[CW-1:0];
          pdct_pkg::REG_PREDIV:  div_set_nxt = s1_req_r.write_data[DW-1:0];
          default: ;
        endcase
      end
      pdct_pkg::CMD_READ: begin
        unique case (s1_req_r.reg_index)
          pdct_pkg::REG_LOAD,
          pdct_pkg::REG_RELOAD:  rd = 32'(reload_r);
          pdct_pkg::REG_VALUE:   rd = 32'(count_r);
          pdct_pkg::REG_CONTROL: rd = 32'(ctrl_r);
          pdct_pkg::REG_RAW:     rd = 32'(irq_r);
          pdct_pkg::REG_MASKED:  rd = 32'(irq_r & ctrl_r[pdct_pkg::CTL_IRQ_EN_BIT]);
          pdct_pkg::REG_PREDIV:  rd = 32'(div_set_r);
          default:               rd = '0;
        endcase
      end
      pdct_pkg::CMD_TICK: begin
        if (div_cnt_r >= div_set_r) begin
          div_cnt_nxt = '0;
          presc_nxt   = presc_r + PW'(1);
          if (((presc_r & pmask) == pmask) && ctrl_r[pdct_pkg::CTL_ENABLE_BIT]) begin
            if (count_m == '0) begin
              irq_nxt   = 1'b1;
              count_nxt = reload_r & cmask;
            end else begin
              count_nxt = (count_m - CW'(1)) & cmask;
            end
          end
        end else begin
          div_cnt_nxt = div_cnt_r + DW'(1);
        end
      end
      default: ;
    endcase
    rsp_nxt.read_data = rd;
    rsp_nxt.irq_line  = irq_nxt & ctrl_nxt[pdct_pkg::CTL_IRQ_EN_BIT];
    rsp_nxt.irq_raw   = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reload_r    <= '0;
      count_r     <= '0;
      ctrl_r      <= '0;
      div_set_r   <= pdct_pkg::DIV_RESET;
      div_cnt_r   <= '0;
      presc_r     <= '0;
      irq_r       <= 1'b0;
    end else begin
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        reload_r    <= reload_nxt;
        count_r     <= count_nxt;
        ctrl_r      <= ctrl_nxt;
        div_set_r   <= div_set_nxt;
        div_cnt_r   <= div_cnt_nxt;
        presc_r     <= presc_nxt;
        irq_r       <= irq_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      s1_req_r <= in_req.data;
    end
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  a_raw_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rsp_r.irq_raw == irq_r))
    else $error("Result pending bit differs from the stored pending bit.");

  a_line_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rsp_r.irq_line == (irq_r & ctrl_r[pdct_pkg::CTL_IRQ_EN_BIT])))
    else $error("Result interrupt line differs from the stored state.");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |=> ($stable(count_r) && $stable(irq_r)
                                         && $stable(div_cnt_r) && $stable(presc_r)))
    else $error("Timer state changed while a result was stalled.");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_req.ready)
    else $error("Request refused with an empty input register.");

  a_reset_empties: assert property (@(posedge clk)
    !$past(rst_n) |-> (!out_valid_r && !s1_valid_r))
    else $error("Pipeline not empty after reset.");

endmodule
